@@ rtl/core/assert_macros.svh @@
// Assertion macros used by button_click_classifier.sv. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of aclk, suspended while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bcc_pkg.sv @@
`default_nettype none

package bcc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned ADDR_W = 2;

    typedef logic [ADDR_W-1:0] cfg_addr_t;

    // Register indexes on the configuration port.
    localparam cfg_addr_t REG_DEBOUNCE     = 2'd0;
    localparam cfg_addr_t REG_LONG_PRESS   = 2'd1;
    localparam cfg_addr_t REG_DOUBLE_CLICK = 2'd2;

    // Values after reset.
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd200;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd600;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd400;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] click_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        logic [TIME_W-1:0] click_stamp;
        logic              held_flag;
        logic              click_waiting;
    } state_t;

    // Declared from the top bit down, so that ignored sits in bit 0.
    typedef struct packed {
        logic button_down;
        logic long_press;
        logic double_click;
        logic release_event;
        logic press_event;
        logic ignored;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

@@ rtl/core/bcc_classify.sv @@
`default_nettype none

// Classifies one button edge against the stored stamps and gives the
// result together with the state that follows it.
module bcc_classify (
    input  wire logic                       pin_level,
    input  wire logic [bcc_pkg::TIME_W-1:0] time_ms,
    input  wire bcc_pkg::cfg_t              cfg,
    input  wire bcc_pkg::state_t            state,
    output bcc_pkg::result_t                result,
    output bcc_pkg::state_t                 state_next
);

    logic [bcc_pkg::TIME_W-1:0] since_press;
    logic [bcc_pkg::TIME_W-1:0] since_release;
    logic [bcc_pkg::TIME_W-1:0] since_click;
    logic                       press_too_soon;
    logic                       release_too_soon;
    logic                       in_window;
    logic                       held_long;

    // Differences wrap modulo 2^32, exactly as the tick counter does.
    assign since_press      = time_ms - state.press_stamp;
    assign since_release    = time_ms - state.release_stamp;
    assign since_click      = time_ms - state.click_stamp;
    assign press_too_soon   = since_press < {16'd0, cfg.debounce_ms};
    assign release_too_soon = since_release < {16'd0, cfg.debounce_ms};
    assign in_window        = since_click <= {16'd0, cfg.click_gap_ms};
    assign held_long        = since_press >= {16'd0, cfg.long_press_ms};

    always_comb begin
        state_next = state;
        result     = '0;
        if (pin_level) begin
            if (press_too_soon) begin
                result.ignored = 1'b1;
            end else begin
                state_next.press_stamp = time_ms;
                state_next.held_flag   = 1'b1;
                result.press_event     = 1'b1;
                if (state.click_waiting && in_window) begin
                    result.double_click      = 1'b1;
                    state_next.click_waiting = 1'b0;
                end else begin
                    state_next.click_waiting = 1'b1;
                    state_next.click_stamp   = time_ms;
                end
            end
        end else begin
            if (release_too_soon) begin
                result.ignored = 1'b1;
            end else begin
                state_next.release_stamp = time_ms;
                state_next.held_flag     = 1'b0;
                result.release_event     = 1'b1;
                if (held_long) begin
                    result.long_press        = 1'b1;
                    state_next.click_waiting = 1'b0;
                end
            end
        end
        result.button_down = state_next.held_flag;
    end

endmodule

`default_nettype wire

@@ rtl/core/button_click_classifier.sv @@
// Button click classifier. Every item on the input stream is one button edge:
// s_tuser carries the sampled pin level (1 pressed, 0 released) and s_tdata the
// free-running millisecond tick count at that edge, which may wrap. For every
// item exactly one result item leaves on the output stream, in order, with
// six flags: ignored (the edge came within debounce_ms of the last accepted
// edge of the same kind), press_event, release_event, double_click (a press
// within click_gap_ms of a waiting click), long_press (a release at least
// long_press_ms after the last accepted press, which also cancels the waiting
// click) and button_down, the debounced level after the edge. The block takes
// one item per clock cycle as long as the output is not stalled. An accepted
// item is held in the input register and classified from there, and its
// result is loaded into the result register and offered from it. The
// classification of each item, which updates the stamps seen by the next, is
// done combinationally between the two registers. A stall on the output
// holds the result register, and once the input register is full as well,
// s_tready falls. The three timing registers are written through cfg_we,
// cfg_addr and cfg_wdata, and are to be changed only while no item is in
// flight; after reset they hold 200, 600 and 400 ms, and all stamps are zero,
// so an edge earlier than debounce_ms after tick zero is ignored.
`default_nettype none

`include "assert_macros.svh"

module button_click_classifier (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [bcc_pkg::ADDR_W-1:0]     cfg_addr,
    input  wire logic [bcc_pkg::CFG_W-1:0]      cfg_wdata,

    // Input stream of button edges.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bcc_pkg::TIME_W-1:0]     s_tdata,  // [31:0] time_ms
    input  wire logic                           s_tuser,  // [0] pin_level

    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] ignored, [1] press_event, [2] release_event, [3] double_click,
    // [4] long_press, [5] button_down, [7:6] zero
    output logic [7:0]                          m_tdata
);

    // Input register.
    logic                       in_valid_reg;
    logic                       in_level_reg;
    logic [bcc_pkg::TIME_W-1:0] in_time_reg;

    // Result register.
    logic                       out_valid_reg;
    bcc_pkg::result_t           result_reg;

    // Timing registers and classifier state.
    bcc_pkg::cfg_t              cfg_reg;
    bcc_pkg::state_t            state_reg;

    bcc_pkg::result_t           result_next;
    bcc_pkg::state_t            state_next;

    logic                       advance;
    logic                       s_accept;

    // An item moves from the input register to the result register whenever
    // the result register is empty or is being emptied in this cycle. The
    // state is committed at the same moment, so the item behind sees it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    bcc_classify u_classify (
        .pin_level  (in_level_reg),
        .time_ms    (in_time_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg.debounce_ms   <= bcc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= bcc_pkg::LONG_PRESS_RESET;
            cfg_reg.click_gap_ms  <= bcc_pkg::DOUBLE_CLICK_RESET;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // Writes to an index beyond the list have no effect.
            if (cfg_we) begin
                unique case (cfg_addr)
                    bcc_pkg::REG_DEBOUNCE:     cfg_reg.debounce_ms   <= cfg_wdata;
                    bcc_pkg::REG_LONG_PRESS:   cfg_reg.long_press_ms <= cfg_wdata;
                    bcc_pkg::REG_DOUBLE_CLICK: cfg_reg.click_gap_ms  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg <= s_tuser;
            in_time_reg  <= s_tdata;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

    // A result with an event flag is never marked ignored, and the secondary
    // flags only ride on their own kind of event.
    `ASSERT_CLK(a_ignored_clean, out_valid_reg && result_reg.ignored |-> result_reg[4:1] == 4'd0, "ignored item carries event flags")
    `ASSERT_CLK(a_double_on_press, out_valid_reg && result_reg.double_click |-> result_reg.press_event, "double click without press")
    `ASSERT_CLK(a_long_on_release, out_valid_reg && result_reg.long_press |-> result_reg.release_event, "long press without release")
    // The debounced level shown must match the state committed with it.
    `ASSERT_NEXT(a_level_matches_state, advance, result_reg.button_down == state_reg.held_flag, "button_down differs from held state")
    // An accepted press always leaves a click waiting or reports a double click.
    `ASSERT_NEXT(a_press_click, advance && result_next.press_event, state_reg.click_waiting || result_reg.double_click, "press left no click state")

endmodule

`default_nettype wire

@@ sim/tb_button_click_classifier.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the button click classifier. Button edges go in on
// the input stream, and every result item is checked flag by flag against a
// local model of the debounce, double-click and long-press rules.
module tb_button_click_classifier;

    // The fourth register index exists on the port but maps to nothing.
    localparam bcc_pkg::cfg_addr_t REG_UNUSED = 2'd3;

    localparam logic LEVEL_PRESS   = 1'b1;
    localparam logic LEVEL_RELEASE = 1'b0;

    // Longest gap or stall, in cycles, that either side inserts per item.
    localparam int MAX_WAIT    = 9;
    // Bound on the wait for outstanding results whenever the input is drained.
    localparam int DRAIN_LIMIT = 2000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 90;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    bcc_pkg::cfg_addr_t           cfg_addr;
    logic [bcc_pkg::CFG_W-1:0]    cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [bcc_pkg::TIME_W-1:0]   s_tdata;    // [31:0] time_ms
    logic                         s_tuser;    // [0] pin_level
    logic                         m_tvalid;
    logic                         m_tready;
    // [0] ignored, [1] press_event, [2] release_event, [3] double_click,
    // [4] long_press, [5] button_down, [7:6] zero
    logic [7:0]                   m_tdata;

    button_click_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Local copy of the timing registers and of the classifier state.
    logic [bcc_pkg::CFG_W-1:0]  debounce_ms_q;
    logic [bcc_pkg::CFG_W-1:0]  long_press_ms_q;
    logic [bcc_pkg::CFG_W-1:0]  click_gap_ms_q;
    logic [bcc_pkg::TIME_W-1:0] press_stamp_q;
    logic [bcc_pkg::TIME_W-1:0] release_stamp_q;
    logic [bcc_pkg::TIME_W-1:0] click_stamp_q;
    logic                       held_q;
    logic                       click_waiting_q;

    // Classifications still waiting for their result item, oldest first.
    bcc_pkg::result_t pending_flags[$];
    bcc_pkg::result_t seen_flags;
    bcc_pkg::result_t due_flags;
    int               flag_idx;
    string            flag_names [0:bcc_pkg::RESULT_W-1] = '{"ignored", "press_event",
                                                            "release_event", "double_click",
                                                            "long_press", "button_down"};

    int                         error_count;
    bit                         src_gaps_on;
    bit                         sink_stalls_on;
    // Timestamp and level of the most recent item sent, for building sequences.
    logic [bcc_pkg::TIME_W-1:0] clock_ms;
    logic                       last_level;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Classify one accepted edge exactly as the block should, updating the
    // local state. All differences are taken modulo 2^32 by the 32-bit width.
    function automatic bcc_pkg::result_t classify_event(input logic level,
                                                        input logic [bcc_pkg::TIME_W-1:0] now);
        bcc_pkg::result_t           flags;
        logic [bcc_pkg::TIME_W-1:0] since_press;
        logic [bcc_pkg::TIME_W-1:0] since_release;
        logic [bcc_pkg::TIME_W-1:0] since_click;
        since_press   = now - press_stamp_q;
        since_release = now - release_stamp_q;
        since_click   = now - click_stamp_q;
        flags = '0;
        if (level == LEVEL_PRESS) begin
            if (since_press < debounce_ms_q) begin
                flags.ignored = 1'b1;
            end else begin
                press_stamp_q     = now;
                held_q            = 1'b1;
                flags.press_event = 1'b1;
                // A second press close enough to the waiting click completes
                // a double click; anything else opens a new waiting click.
                if (click_waiting_q && since_click <= click_gap_ms_q) begin
                    flags.double_click = 1'b1;
                    click_waiting_q    = 1'b0;
                end else begin
                    click_waiting_q = 1'b1;
                    click_stamp_q   = now;
                end
            end
        end else begin
            if (since_release < debounce_ms_q) begin
                flags.ignored = 1'b1;
            end else begin
                release_stamp_q     = now;
                held_q              = 1'b0;
                flags.release_event = 1'b1;
                // A long hold cancels any click that was waiting.
                if (since_press >= long_press_ms_q) begin
                    flags.long_press = 1'b1;
                    click_waiting_q  = 1'b0;
                end
            end
        end
        flags.button_down = held_q;
        return flags;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Offer one button edge, after a random gap when gaps are on, and hold it
    // until the block takes it. The valid is left high on return, so that a
    // following item with no gap follows on directly.
    task automatic send_event(input logic level, input logic [bcc_pkg::TIME_W-1:0] stamp);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = level;
        s_tdata  = stamp;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_flags.push_back(classify_event(level, stamp));
        last_level = level;
        clock_ms   = stamp;
    endtask

    // Stop sending and wait until every outstanding result has come out,
    // then let the two pipeline stages settle.
    task automatic drain_results;
        int waited;
        @(negedge aclk);
        s_tvalid = 1'b0;
        waited = 0;
        while (pending_flags.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (4) @(negedge aclk);
    endtask

    // Registers are only written with the block idle, so the local copy can
    // be updated straight away.
    task automatic write_reg(input bcc_pkg::cfg_addr_t addr,
                             input logic [bcc_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (addr)
            bcc_pkg::REG_DEBOUNCE:     debounce_ms_q   = value;
            bcc_pkg::REG_LONG_PRESS:   long_press_ms_q = value;
            bcc_pkg::REG_DOUBLE_CLICK: click_gap_ms_q  = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [bcc_pkg::CFG_W-1:0] debounce,
                              input logic [bcc_pkg::CFG_W-1:0] long_hold,
                              input logic [bcc_pkg::CFG_W-1:0] double_gap);
        drain_results();
        write_reg(bcc_pkg::REG_DEBOUNCE, debounce);
        write_reg(bcc_pkg::REG_LONG_PRESS, long_hold);
        write_reg(bcc_pkg::REG_DOUBLE_CLICK, double_gap);
    endtask

    // With the stamps at zero after reset, edges earlier than the debounce
    // time are rejected; a press exactly at the debounce time gets through.
    // Also covers a repeated press while already held.
    task automatic test_power_up_debounce;
        send_event(LEVEL_PRESS,   32'd0);
        send_event(LEVEL_RELEASE, 32'd199);
        send_event(LEVEL_PRESS,   32'd200);
        send_event(LEVEL_PRESS,   32'd250);
        send_event(LEVEL_RELEASE, 32'd300);
    endtask

    // Double click inside the window and exactly on its edge, a press just
    // outside it, a long press and a repeated release, at the reset timings.
    task automatic test_clicks_and_long_press;
        send_event(LEVEL_PRESS,   32'd500);
        send_event(LEVEL_RELEASE, 32'd1200);
        send_event(LEVEL_RELEASE, 32'd1500);
        send_event(LEVEL_PRESS,   32'd1900);
        send_event(LEVEL_PRESS,   32'd2300);
        send_event(LEVEL_PRESS,   32'd2701);
        send_event(LEVEL_PRESS,   32'd3102);
        send_event(LEVEL_RELEASE, 32'd3200);
    endtask

    // The tick counter runs through its top value: a double click is measured
    // across the wrap, followed by a long press.
    task automatic test_counter_wrap;
        send_event(LEVEL_PRESS,   32'hFFFF_FF00);
        send_event(LEVEL_RELEASE, 32'hFFFF_FFFF);
        send_event(LEVEL_PRESS,   32'h0000_0050);
        send_event(LEVEL_RELEASE, 32'h0000_0400);
    endtask

    // All three registers at zero, then all at their maximum, after which a write
    // to the unused index must leave the timings alone.
    task automatic test_timing_extremes;
        set_timing(16'h0000, 16'h0000, 16'h0000);
        send_event(LEVEL_PRESS,   32'h1234_5678);
        send_event(LEVEL_PRESS,   32'h1234_5678);
        send_event(LEVEL_RELEASE, 32'h1234_5679);
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h0000);
        send_event(LEVEL_PRESS,   32'h1234_5679);
        send_event(LEVEL_PRESS,   32'h1235_5678);
        send_event(LEVEL_RELEASE, 32'h1236_5677);
        send_event(LEVEL_PRESS,   32'h1237_5678);
    endtask

    // Mostly alternating presses and releases whose spacing is drawn around
    // the current thresholds, so that bounces, double clicks and long presses
    // all turn up; the rest is random levels and arbitrary timestamps.
    task automatic test_random_traffic;
        logic                       level;
        logic [bcc_pkg::TIME_W-1:0] stamp;
        logic [bcc_pkg::TIME_W-1:0] delta;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_timing(bcc_pkg::DEBOUNCE_RESET, bcc_pkg::LONG_PRESS_RESET,
                              bcc_pkg::DOUBLE_CLICK_RESET);
                1: set_timing(16'($urandom_range(1, 50)), 16'($urandom_range(50, 300)),
                              16'($urandom_range(20, 200)));
                2: set_timing(16'($urandom_range(0, 16'hFFFF)),
                              16'($urandom_range(0, 16'hFFFF)),
                              16'($urandom_range(0, 16'hFFFF)));
                3: set_timing(16'h0000, 16'($urandom_range(0, 1000)), 16'hFFFF);
                default: set_timing(16'($urandom_range(0, 2000)),
                                    16'($urandom_range(0, 4000)),
                                    16'($urandom_range(0, 3000)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // New idling pattern every thirty items, sometimes none at all.
                if (n % 30 == 0) begin
                    src_gaps_on    = $urandom_range(0, 3) != 0;
                    sink_stalls_on = $urandom_range(0, 3) != 0;
                end
                // Once, hold the input back until the output has caught up.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(0, 99) < 85) begin
                    level = ~last_level;
                    case ($urandom_range(0, 4))
                        0: delta = $urandom_range(0, debounce_ms_q);
                        1: delta = $urandom_range(0, click_gap_ms_q / 2);
                        2: delta = debounce_ms_q + $urandom_range(0, click_gap_ms_q);
                        3: delta = long_press_ms_q + $urandom_range(0, 4) - 2;
                        default: delta = $urandom_range(0, 200000);
                    endcase
                    stamp = clock_ms + delta;
                end else begin
                    level = 1'($urandom_range(0, 1));
                    stamp = $urandom_range(0, 1) ? $urandom() : clock_ms + $urandom_range(0, 50);
                end
                send_event(level, stamp);
            end
        end
    endtask

    // Result side: a random stall, when stalls are on, before each item is taken,
    // drawn afresh after every accepted item.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = sink_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
            @(negedge aclk);
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Every accepted result item is matched with the oldest classification.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_flags = bcc_pkg::result_t'(m_tdata[bcc_pkg::RESULT_W-1:0]);
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("result %02h with no item outstanding", m_tdata));
            end else begin
                due_flags = pending_flags.pop_front();
                for (flag_idx = 0; flag_idx < bcc_pkg::RESULT_W; flag_idx++) begin
                    if (seen_flags[flag_idx] !== due_flags[flag_idx])
                        report_mismatch($sformatf("%s is %b, expected %b",
                                                  flag_names[flag_idx], seen_flags[flag_idx],
                                                  due_flags[flag_idx]));
                end
                if (m_tdata[7:bcc_pkg::RESULT_W] !== '0)
                    report_mismatch($sformatf("padding bits are %b",
                                              m_tdata[7:bcc_pkg::RESULT_W]));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = bcc_pkg::REG_DEBOUNCE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = LEVEL_RELEASE;
        s_tdata   = '0;

        error_count     = 0;
        src_gaps_on     = 1'b1;
        sink_stalls_on  = 1'b1;
        clock_ms        = '0;
        last_level      = LEVEL_RELEASE;
        debounce_ms_q   = bcc_pkg::DEBOUNCE_RESET;
        long_press_ms_q = bcc_pkg::LONG_PRESS_RESET;
        click_gap_ms_q  = bcc_pkg::DOUBLE_CLICK_RESET;
        press_stamp_q   = '0;
        release_stamp_q = '0;
        click_stamp_q   = '0;
        held_q          = 1'b0;
        click_waiting_q = 1'b0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_power_up_debounce();
        test_clicks_and_long_press();
        test_counter_wrap();
        test_timing_extremes();
        test_random_traffic();

        drain_results();
        if (pending_flags.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_flags.size()));

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
